// ----- rtl/ltw_pkg.sv -----
// shared types and constants for the link traffic watchdog
package ltw_pkg;

    localparam int CNT_W     = 16;
    localparam int TRAFFIC_W = 32;
    localparam int TIME_W    = 40;
    localparam int TMO_W     = 20;
    localparam int CODE_W    = 3;
    localparam int STATUS_W  = 3;
    localparam int NUDGE_W   = 2;

    localparam logic [CNT_W-1:0] NUDGE_INT_RST = 16'd10;
    localparam logic [CNT_W-1:0] RESET_INT_RST = 16'd30;
    localparam logic [TMO_W-1:0] DHCP_TMO_RST  = 20'd32000;

    // register indexes on the config port
    localparam logic [1:0] REG_NUDGE_INT = 2'd0;
    localparam logic [1:0] REG_RESET_INT = 2'd1;
    localparam logic [1:0] REG_DHCP_TMO  = 2'd2;

    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_EVENT = 1'b1;

    localparam logic [CODE_W-1:0] EV_UP        = 3'd0;
    localparam logic [CODE_W-1:0] EV_DOWN      = 3'd1;
    localparam logic [CODE_W-1:0] EV_DHCP_BEG  = 3'd2;
    localparam logic [CODE_W-1:0] EV_DHCP_RTRY = 3'd3;
    localparam logic [CODE_W-1:0] EV_DNS_TMO   = 3'd4;
    localparam logic [CODE_W-1:0] EV_RST_MET   = 3'd5;
    localparam logic [CODE_W-1:0] EV_SHOW_MET  = 3'd6;

    localparam logic [STATUS_W-1:0] ST_UP       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DOWN     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_IP    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DNS_TMO  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RST_MET  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_SHOW_MET = 3'd5;

    localparam logic [NUDGE_W-1:0] NUDGE_NONE  = 2'd0;
    localparam logic [NUDGE_W-1:0] NUDGE_SOFT  = 2'd1;
    localparam logic [NUDGE_W-1:0] NUDGE_RESET = 2'd2;

    typedef struct packed {
        logic done;
        logic zero;
    } ltw_rem_res_t;

endpackage

// ----- rtl/ltw_rem_unit.sv -----
// bit-serial restoring remainder, flags a zero remainder after one step per dividend bit
module ltw_rem_unit
    import ltw_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [CNT_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output ltw_rem_res_t     res
);

    localparam int STEP_W = $clog2(CNT_W);

    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  dvd_reg, dvd_next;
    logic [CNT_W-1:0]  dvs_reg;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;

    // one quotient bit per cycle
    assign trial = {rem_reg, dvd_reg[CNT_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        if (start) begin
            rem_next  = '0;
            dvd_next  = dividend;
            step_next = STEP_W'(CNT_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[CNT_W-2:0], 1'b0};
            if (!diff[CNT_W]) begin
                rem_next = diff[CNT_W-1:0];
            end else begin
                rem_next = trial[CNT_W-1:0];
            end
            step_next = step_reg - STEP_W'(1);
            if (step_reg == '0) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        if (start) begin
            dvs_reg <= divisor;
        end
    end

    assign res.done = !busy_reg;
    assign res.zero = (rem_reg == '0);

endmodule

// ----- rtl/link_traffic_watchdog_unit.sv -----
// link traffic watchdog: silent-tick nudges, link state and dhcp timeout reporting
// a silent tick goes from S_IDLE through S_DIV, where it waits on the two
// 16-step bit-serial remainder units that test the count against both intervals,
// to S_OUT; every other tick or event goes from S_IDLE straight to S_OUT
// the next word is taken once the previous result sits in the output register
// aresetn is synchronous, active low: state clears, registers return to defaults
module link_traffic_watchdog_unit
    import ltw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // op_count[31:0], event_code[34:32], now_ms[74:35], zero fill
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // status_valid[0], status[3:1], nudge[5:4], net_up[6], zero fill
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_OUT  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]            nudge_int_reg, reset_int_reg;
    logic [TMO_W-1:0]            dhcp_tmo_reg;
    logic signed [TRAFFIC_W-1:0] last_traffic_reg, last_traffic_next;
    logic [CNT_W-1:0]            silent_reg, silent_next;
    logic                        link_up_reg, link_up_next;
    logic [TIME_W-1:0]           dhcp_beg_reg, dhcp_beg_next;

    logic                        valid_reg, valid_next;
    logic [STATUS_W-1:0]         status_reg, status_next;
    logic [NUDGE_W-1:0]          nudge_reg, nudge_next;

    logic                        m_tvalid_reg, m_tvalid_next;
    logic [7:0]                  m_tdata_reg;

    logic signed [TRAFFIC_W-1:0] op_count;
    logic [CODE_W-1:0]           event_code;
    logic [TIME_W-1:0]           now_ms;
    logic                        accept;
    logic                        div_start;
    logic                        out_load;
    logic [TIME_W:0]             wait_ms;
    logic                        reset_hit, nudge_hit;
    logic                        cfg_wr;
    ltw_rem_res_t                rem_nudge, rem_reset;

    assign op_count   = $signed(s_tdata[31:0]);
    assign event_code = s_tdata[34:32];
    assign now_ms     = s_tdata[74:35];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    // borrow in the top bit means the clock is behind the start time
    assign wait_ms = {1'b0, now_ms} - {1'b0, dhcp_beg_reg};

    assign reset_hit = (reset_int_reg != '0) && rem_reset.zero;
    assign nudge_hit = (nudge_int_reg != '0) && rem_nudge.zero;

    always_comb begin
        state_next        = state_reg;
        last_traffic_next = last_traffic_reg;
        silent_next       = silent_reg;
        link_up_next      = link_up_reg;
        dhcp_beg_next     = dhcp_beg_reg;
        valid_next        = valid_reg;
        status_next       = status_reg;
        nudge_next        = nudge_reg;
        div_start         = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    valid_next  = 1'b0;
                    status_next = ST_UP;
                    nudge_next  = NUDGE_NONE;
                    state_next  = S_OUT;
                    if (s_tuser == KIND_TICK) begin
                        if (op_count < 0) begin
                            last_traffic_next = '1;
                        end else if (op_count > last_traffic_reg) begin
                            last_traffic_next = op_count;
                            silent_next       = '0;
                        end else begin
                            silent_next = silent_reg + CNT_W'(1);
                            div_start   = 1'b1;
                            state_next  = S_DIV;
                        end
                    end else begin
                        case (event_code)
                            EV_UP: begin
                                if (!link_up_reg) begin
                                    link_up_next      = 1'b1;
                                    last_traffic_next = '0;
                                    dhcp_beg_next     = '0;
                                    valid_next        = 1'b1;
                                    status_next       = ST_UP;
                                end
                            end
                            EV_DOWN: begin
                                link_up_next  = 1'b0;
                                dhcp_beg_next = '0;
                                valid_next    = 1'b1;
                                status_next   = ST_DOWN;
                            end
                            EV_DHCP_BEG: begin
                                dhcp_beg_next = now_ms;
                            end
                            EV_DHCP_RTRY: begin
                                if (dhcp_beg_reg != '0 && !wait_ms[TIME_W] &&
                                    wait_ms[TIME_W-1:0] >= TIME_W'(dhcp_tmo_reg)) begin
                                    valid_next  = 1'b1;
                                    status_next = ST_NO_IP;
                                end
                            end
                            EV_DNS_TMO: begin
                                valid_next  = 1'b1;
                                status_next = ST_DNS_TMO;
                            end
                            EV_RST_MET: begin
                                valid_next  = 1'b1;
                                status_next = ST_RST_MET;
                            end
                            EV_SHOW_MET: begin
                                valid_next  = 1'b1;
                                status_next = ST_SHOW_MET;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            S_DIV: begin
                if (rem_nudge.done && rem_reset.done) begin
                    // link reset outranks the soft nudge
                    if (reset_hit) begin
                        nudge_next        = NUDGE_RESET;
                        last_traffic_next = '0;
                    end else if (nudge_hit) begin
                        nudge_next        = NUDGE_SOFT;
                        last_traffic_next = '0;
                    end
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    ltw_rem_unit u_rem_nudge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (silent_next),
        .divisor  (nudge_int_reg),
        .res      (rem_nudge)
    );

    ltw_rem_unit u_rem_reset (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (silent_next),
        .divisor  (reset_int_reg),
        .res      (rem_reset)
    );

    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            m_tvalid_reg     <= 1'b0;
            last_traffic_reg <= '0;
            silent_reg       <= '0;
            link_up_reg      <= 1'b0;
            dhcp_beg_reg     <= '0;
            nudge_int_reg    <= NUDGE_INT_RST;
            reset_int_reg    <= RESET_INT_RST;
            dhcp_tmo_reg     <= DHCP_TMO_RST;
        end else begin
            state_reg        <= state_next;
            m_tvalid_reg     <= m_tvalid_next;
            last_traffic_reg <= last_traffic_next;
            silent_reg       <= silent_next;
            link_up_reg      <= link_up_next;
            dhcp_beg_reg     <= dhcp_beg_next;
            if (cfg_wr) begin
                case (paddr[3:2])
                    REG_NUDGE_INT: nudge_int_reg <= pwdata[CNT_W-1:0];
                    REG_RESET_INT: reset_int_reg <= pwdata[CNT_W-1:0];
                    REG_DHCP_TMO:  dhcp_tmo_reg  <= pwdata[TMO_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        valid_reg  <= valid_next;
        status_reg <= status_next;
        nudge_reg  <= nudge_next;
        if (out_load) begin
            m_tdata_reg <= {1'b0, link_up_reg, nudge_reg, status_reg, valid_reg};
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_NUDGE_INT: prdata = {16'd0, nudge_int_reg};
            REG_RESET_INT: prdata = {16'd0, reset_int_reg};
            REG_DHCP_TMO:  prdata = {12'd0, dhcp_tmo_reg};
            default:       prdata = '0;
        endcase
    end

    assign pready   = 1'b1;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- tb/sv/tb.sv -----
// self-checking testbench for the link traffic watchdog unit
`timescale 1ns / 100ps

module tb;
    import ltw_pkg::*;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 300;
    localparam int SEGMENTS      = 12;
    localparam int SEG_WORDS     = 138;

    localparam logic [1:0]          REG_UNUSED  = 2'd3;
    localparam logic [STATUS_W-1:0] STATUS_NONE = '0;

    // result word, status_valid in bit 0
    typedef struct packed {
        logic                net_up;
        logic [NUDGE_W-1:0]  nudge;
        logic [STATUS_W-1:0] status;
        logic                status_valid;
    } status_word_t;

    typedef struct {
        bit                   is_write;
        logic [1:0]           reg_idx;
        logic [31:0]          reg_val;
        bit                   typed;
        logic                 kind;
        logic [TRAFFIC_W-1:0] op;
        logic [CODE_W-1:0]    code;
        logic [TIME_W-1:0]    now;
        status_word_t         want;
    } plan_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;   // op_count[31:0], event_code[34:32], now_ms[74:35], zero fill
    logic        s_tuser;   // kind
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // status_valid[0], status[3:1], nudge[5:4], net_up[6], zero fill
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    link_traffic_watchdog_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // predictor copy of the block state and registers
    logic signed [TRAFFIC_W-1:0] wd_last;
    logic [CNT_W-1:0]            wd_silent;
    logic                        wd_up;
    logic [TIME_W-1:0]           wd_dhcp_at;
    logic [CNT_W-1:0]            cfg_nudge;
    logic [CNT_W-1:0]            cfg_reset;
    logic [TMO_W-1:0]            cfg_tmo;

    status_word_t pending_status[$];
    plan_row_t    plan[$];

    int error_count;
    int words_sent;
    int words_checked;
    int settings_used;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_request;
    bit hold_done;
    int hold_left;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic status_word_t watchdog_predict(input logic kind,
                                                      input logic signed [TRAFFIC_W-1:0] traffic,
                                                      input logic [CODE_W-1:0] code,
                                                      input logic [TIME_W-1:0] now);
        status_word_t r;
        r = '0;
        if (kind == KIND_TICK) begin
            if (traffic < 0) begin
                wd_last = -1;
            end else if (traffic > wd_last) begin
                wd_last   = traffic;
                wd_silent = '0;
            end else begin
                wd_silent = wd_silent + 16'd1;
                // link reset wins over the soft nudge
                if (cfg_reset != 0 && wd_silent % cfg_reset == 0) begin
                    r.nudge = NUDGE_RESET;
                    wd_last = '0;
                end else if (cfg_nudge != 0 && wd_silent % cfg_nudge == 0) begin
                    r.nudge = NUDGE_SOFT;
                    wd_last = '0;
                end
            end
        end else begin
            case (code)
                EV_UP: begin
                    if (!wd_up) begin
                        wd_up          = 1'b1;
                        wd_last        = '0;
                        wd_dhcp_at     = '0;
                        r.status_valid = 1'b1;
                        r.status       = ST_UP;
                    end
                end
                EV_DOWN: begin
                    wd_up          = 1'b0;
                    wd_dhcp_at     = '0;
                    r.status_valid = 1'b1;
                    r.status       = ST_DOWN;
                end
                EV_DHCP_BEG: begin
                    wd_dhcp_at = now;
                end
                EV_DHCP_RTRY: begin
                    // clock behind the start time counts as not elapsed
                    if (wd_dhcp_at != 0 && now >= wd_dhcp_at &&
                        now - wd_dhcp_at >= TIME_W'(cfg_tmo)) begin
                        r.status_valid = 1'b1;
                        r.status       = ST_NO_IP;
                    end
                end
                EV_DNS_TMO: begin
                    r.status_valid = 1'b1;
                    r.status       = ST_DNS_TMO;
                end
                EV_RST_MET: begin
                    r.status_valid = 1'b1;
                    r.status       = ST_RST_MET;
                end
                EV_SHOW_MET: begin
                    r.status_valid = 1'b1;
                    r.status       = ST_SHOW_MET;
                end
                default: begin
                end
            endcase
        end
        r.net_up = wd_up;
        return r;
    endfunction

    function automatic status_word_t status_of(input logic valid, input logic [STATUS_W-1:0] st,
                                               input logic [NUDGE_W-1:0] ng, input logic up);
        status_word_t r;
        r.status_valid = valid;
        r.status       = st;
        r.nudge        = ng;
        r.net_up       = up;
        return r;
    endfunction

    function automatic plan_row_t item_row(input logic kind, input logic [TRAFFIC_W-1:0] op,
                                           input logic [CODE_W-1:0] code,
                                           input logic [TIME_W-1:0] now,
                                           input bit typed, input status_word_t want);
        plan_row_t r;
        r          = '{default: '0};
        r.kind     = kind;
        r.op       = op;
        r.code     = code;
        r.now      = now;
        r.typed    = typed;
        r.want     = want;
        return r;
    endfunction

    function automatic plan_row_t write_row(input logic [1:0] idx, input logic [31:0] val);
        plan_row_t r;
        r          = '{default: '0};
        r.is_write = 1'b1;
        r.reg_idx  = idx;
        r.reg_val  = val;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [7:0] got,
                                   input logic [7:0] want);
        error_count++;
        $display("mismatch on %s at word %0d: got %0h, expected %0h",
                 field, words_checked, got, want);
    endtask

    task automatic send_word(input logic kind, input logic [TRAFFIC_W-1:0] op,
                             input logic [CODE_W-1:0] code, input logic [TIME_W-1:0] now,
                             input bit typed, input status_word_t want);
        int           gap;
        status_word_t predicted;
        gap = 0;
        while (gap < 20 && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {5'b0, now, code, op};
        do @(posedge aclk); while (!s_tready);
        predicted = watchdog_predict(kind, op, code, now);
        pending_status.push_back(typed ? want : predicted);
        words_sent++;
    endtask

    // block is idle once every result is back and the tail latency has passed
    task automatic settle_outputs();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_status.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_NUDGE_INT: cfg_nudge = val[CNT_W-1:0];
            REG_RESET_INT: cfg_reset = val[CNT_W-1:0];
            REG_DHCP_TMO:  cfg_tmo   = val[TMO_W-1:0];
            default: begin
            end
        endcase
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        m_tready  = 1'b0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin : check_output
        status_word_t got;
        status_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = status_word_t'(m_tdata[6:0]);
            if (pending_status.size() == 0) begin
                report_mismatch("unexpected word", m_tdata, 8'h00);
            end else begin
                want = pending_status.pop_front();
                if (got.status_valid !== want.status_valid)
                    report_mismatch("status_valid", 8'(got.status_valid),
                                    8'(want.status_valid));
                if (got.status !== want.status)
                    report_mismatch("status", 8'(got.status), 8'(want.status));
                if (got.nudge !== want.nudge)
                    report_mismatch("nudge", 8'(got.nudge), 8'(want.nudge));
                if (got.net_up !== want.net_up)
                    report_mismatch("net_up", 8'(got.net_up), 8'(want.net_up));
                words_checked++;
            end
        end
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge aclk);
        $display("timeout after %0d cycles, %0d words outstanding",
                 LIMIT_CYCLES, pending_status.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        logic                 kind;
        logic [TRAFFIC_W-1:0] op;
        logic [CODE_W-1:0]    code;
        logic [TIME_W-1:0]    now;
        logic [TIME_W-1:0]    clock_ms;
        logic [31:0]          nudge_val;
        logic [31:0]          reset_val;
        logic [31:0]          tmo_val;
        int                   pick;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        error_count   = 0;
        words_sent    = 0;
        words_checked = 0;
        settings_used = 1;
        hold_request  = 1'b0;
        send_idle_pct = 25;
        recv_idle_pct = 65;
        clock_ms      = 40'd1;
        wd_last       = '0;
        wd_silent     = '0;
        wd_up         = 1'b0;
        wd_dhcp_at    = '0;
        cfg_nudge     = NUDGE_INT_RST;
        cfg_reset     = RESET_INT_RST;
        cfg_tmo       = DHCP_TMO_RST;

        // directed part under reset defaults, then small and zero intervals
        plan.push_back(item_row(KIND_TICK, 32'd0, 3'd0, 40'd0, 1,
                                status_of(1'b0, STATUS_NONE, NUDGE_NONE, 1'b0)));
        plan.push_back(item_row(KIND_EVENT, 32'd0, EV_UP, 40'd5, 1,
                                status_of(1'b1, ST_UP, NUDGE_NONE, 1'b1)));
        plan.push_back(item_row(KIND_EVENT, 32'd0, EV_UP, 40'd6, 1,
                                status_of(1'b0, STATUS_NONE, NUDGE_NONE, 1'b1)));
        plan.push_back(item_row(KIND_TICK, 32'hFFFF_FFFF, 3'd7, 40'hFF_FFFF_FFFF, 1,
                                status_of(1'b0, STATUS_NONE, NUDGE_NONE, 1'b1)));
        plan.push_back(item_row(KIND_TICK, 32'h7FFF_FFFF, 3'd0, 40'd0, 1,
                                status_of(1'b0, STATUS_NONE, NUDGE_NONE, 1'b1)));
        plan.push_back(item_row(KIND_TICK, 32'h7FFF_FFFF, 3'd0, 40'd0, 1,
                                status_of(1'b0, STATUS_NONE, NUDGE_NONE, 1'b1)));
        plan.push_back(item_row(KIND_EVENT, 32'd0, EV_DHCP_BEG, 40'd0, 1,
                                status_of(1'b0, STATUS_NONE, NUDGE_NONE, 1'b1)));
        plan.push_back(item_row(KIND_EVENT, 32'd0, EV_DHCP_RTRY, 40'hFF_FFFF_FFFF, 1,
                                status_of(1'b0, STATUS_NONE, NUDGE_NONE, 1'b1)));
        plan.push_back(item_row(KIND_EVENT, 32'd0, EV_DHCP_BEG, 40'd1000, 1,
                                status_of(1'b0, STATUS_NONE, NUDGE_NONE, 1'b1)));
        plan.push_back(item_row(KIND_EVENT, 32'd0, EV_DHCP_RTRY, 40'd500, 1,
                                status_of(1'b0, STATUS_NONE, NUDGE_NONE, 1'b1)));
        plan.push_back(item_row(KIND_EVENT, 32'd0, EV_DHCP_RTRY, 40'd32999, 1,
                                status_of(1'b0, STATUS_NONE, NUDGE_NONE, 1'b1)));
        plan.push_back(item_row(KIND_EVENT, 32'd0, EV_DHCP_RTRY, 40'd33000, 1,
                                status_of(1'b1, ST_NO_IP, NUDGE_NONE, 1'b1)));
        plan.push_back(item_row(KIND_EVENT, 32'd0, EV_DHCP_BEG, 40'hFF_FFFF_FFFF, 1,
                                status_of(1'b0, STATUS_NONE, NUDGE_NONE, 1'b1)));
        plan.push_back(item_row(KIND_EVENT, 32'd0, EV_DHCP_RTRY, 40'hFF_FFFF_FFFF, 1,
                                status_of(1'b0, STATUS_NONE, NUDGE_NONE, 1'b1)));
        plan.push_back(item_row(KIND_EVENT, 32'd0, EV_DNS_TMO, 40'd1, 1,
                                status_of(1'b1, ST_DNS_TMO, NUDGE_NONE, 1'b1)));
        plan.push_back(item_row(KIND_EVENT, 32'd0, EV_RST_MET, 40'd1, 1,
                                status_of(1'b1, ST_RST_MET, NUDGE_NONE, 1'b1)));
        plan.push_back(item_row(KIND_EVENT, 32'd0, EV_SHOW_MET, 40'd1, 1,
                                status_of(1'b1, ST_SHOW_MET, NUDGE_NONE, 1'b1)));
        // unknown event code is ignored
        plan.push_back(item_row(KIND_EVENT, 32'hFFFF_FFFF, 3'd7, 40'hFF_FFFF_FFFF, 1,
                                status_of(1'b0, STATUS_NONE, NUDGE_NONE, 1'b1)));
        plan.push_back(item_row(KIND_EVENT, 32'd0, EV_DOWN, 40'd2, 1,
                                status_of(1'b1, ST_DOWN, NUDGE_NONE, 1'b0)));
        plan.push_back(item_row(KIND_EVENT, 32'd0, EV_DOWN, 40'd3, 1,
                                status_of(1'b1, ST_DOWN, NUDGE_NONE, 1'b0)));
        plan.push_back(write_row(REG_NUDGE_INT, 32'd1));
        plan.push_back(write_row(REG_RESET_INT, 32'd3));
        plan.push_back(item_row(KIND_TICK, 32'd0, 3'd0, 40'd0, 0, '0));
        plan.push_back(item_row(KIND_TICK, 32'd0, 3'd0, 40'd0, 0, '0));
        plan.push_back(item_row(KIND_TICK, 32'd0, 3'd0, 40'd0, 0, '0));
        // zero intervals never fire, out-of-range index is dropped
        plan.push_back(write_row(REG_NUDGE_INT, 32'd0));
        plan.push_back(write_row(REG_RESET_INT, 32'd0));
        plan.push_back(write_row(REG_DHCP_TMO, 32'd0));
        plan.push_back(write_row(REG_UNUSED, 32'hFFFF_FFFF));
        plan.push_back(item_row(KIND_TICK, 32'd0, 3'd0, 40'd0, 0, '0));
        plan.push_back(item_row(KIND_TICK, 32'd0, 3'd0, 40'd0, 0, '0));
        plan.push_back(item_row(KIND_EVENT, 32'd0, EV_DHCP_BEG, 40'd7, 0, '0));
        plan.push_back(item_row(KIND_EVENT, 32'd0, EV_DHCP_RTRY, 40'd7, 0, '0));

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].is_write) begin
                settle_outputs();
                reg_write(plan[i].reg_idx, plan[i].reg_val);
                settings_used++;
            end else begin
                send_word(plan[i].kind, plan[i].op, plan[i].code, plan[i].now,
                          plan[i].typed, plan[i].want);
            end
        end

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            if (seg == SEGMENTS / 3) begin
                send_idle_pct = 65;
                recv_idle_pct = 25;
            end else if (seg == 2 * SEGMENTS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (seg)
                0: begin
                    nudge_val = 32'd1;
                    reset_val = 32'd65535;
                    tmo_val   = 32'd0;
                end
                1: begin
                    nudge_val = 32'd65535;
                    reset_val = 32'd1;
                    tmo_val   = 32'd1048575;
                end
                2: begin
                    nudge_val = 32'd0;
                    reset_val = $urandom_range(2, 9);
                    tmo_val   = $urandom_range(0, 40000);
                end
                3: begin
                    nudge_val = $urandom_range(2, 6);
                    reset_val = 32'd0;
                    tmo_val   = $urandom_range(0, 40000);
                end
                default: begin
                    // upper bits are junk the register must drop
                    nudge_val = {16'($urandom_range(0, 65535)), 16'(($urandom_range(1, 12)))};
                    reset_val = {16'($urandom_range(0, 65535)), 16'(($urandom_range(1, 40)))};
                    tmo_val   = {12'(($urandom)), 20'(($urandom_range(0, 40000)))};
                end
            endcase
            settle_outputs();
            reg_write(REG_NUDGE_INT, nudge_val);
            reg_write(REG_RESET_INT, reset_val);
            reg_write(REG_DHCP_TMO, tmo_val);
            if (seg % 4 == 1)
                reg_write(REG_UNUSED, $urandom);
            settings_used++;
            // fill the block while the receiver holds off
            if (seg == 2 * SEGMENTS / 3)
                hold_request = 1'b1;

            for (int n = 0; n < SEG_WORDS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    kind = KIND_TICK;
                    pick = $urandom_range(0, 99);
                    if (pick < 70)
                        op = 32'd0;
                    else if (pick < 80)
                        op = 32'hFFFF_FFFF;
                    else if (pick < 90)
                        op = $urandom_range(1, 5);
                    else
                        op = $urandom & 32'h7FFF_FFFF;
                    code = 3'($urandom_range(0, 7));
                    now  = {8'($urandom), 32'($urandom)};
                end else begin
                    kind = KIND_EVENT;
                    op   = $urandom;
                    pick = $urandom_range(0, 99);
                    if (pick < 30)
                        code = EV_DHCP_RTRY;
                    else if (pick < 45)
                        code = EV_DHCP_BEG;
                    else if (pick < 55)
                        code = EV_UP;
                    else if (pick < 62)
                        code = EV_DOWN;
                    else
                        code = 3'($urandom_range(0, 7));
                    clock_ms = clock_ms + 40'($urandom_range(0, 3000));
                    pick = $urandom_range(0, 99);
                    if (pick < 85)
                        now = clock_ms;
                    else if (pick < 90)
                        now = '0;
                    else
                        now = {8'($urandom), 32'($urandom)};
                end
                send_word(kind, op, code, now, 0, '0);
            end
        end

        settle_outputs();
        if (pending_status.size() != 0)
            report_mismatch("leftover words", 8'(pending_status.size()), 8'h00);
        $display("run covered %0d input words and %0d checked results over %0d settings",
                 words_sent, words_checked, settings_used);
        $display("sender and receiver idling swapped, with one %0d-cycle output hold-off",
                 HOLD_CYCLES);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", error_count);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
